// ===== hw/rtl/isort_pkg.sv =====
// Shared types and constants for the insertion sorter.
// Used by isort_cell and insertion_sorter_top; depends on nothing else.
package isort_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [0:0] {
    ST_LOAD  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic load;      // a word is being inserted this cycle
    logic shift;     // a result word leaves cell 0; the chain moves down by one
    logic occupied;  // this cell holds an element of the current set
    logic tail;      // this cell is the first free one
  } cell_ctl_t;

endpackage

// ===== hw/rtl/isort_cell.sv =====
// One cell of the sorting chain: holds one element of the set.
// Depends on isort_pkg for the value and control types.
module isort_cell (
  input  logic                clk,
  input  isort_pkg::cell_ctl_t ctl,
  input  isort_pkg::value_t   ins_value,
  input  isort_pkg::value_t   left_value,
  input  logic                left_gt,
  input  isort_pkg::value_t   right_value,
  output isort_pkg::value_t   value,
  output logic                gt
);

  isort_pkg::value_t value_r;
  isort_pkg::value_t value_nxt;

  // The new word belongs below this element when the element is strictly greater.
  assign gt    = ctl.occupied && (ins_value < value_r);
  assign value = value_r;

  always_comb begin
    value_nxt = value_r;
    if (ctl.load) begin
      if (left_gt) begin
        value_nxt = left_value;
      end else if (gt || ctl.tail) begin
        value_nxt = ins_value;
      end
    end else if (ctl.shift) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ===== hw/rtl/insertion_sorter_top.sv =====
// Top level of the insertion sorter: a chain of isort_cell instances and the sequencer.
// Depends on isort_pkg and isort_cell.
//
// Words of one set enter at one per cycle and are inserted into a chain of DEPTH cells
// that always holds them in ascending order; every cell compares the incoming word with
// its own element in the same cycle. A word marked last, or the DEPTH-th word of a set,
// closes the set. The set of N words is then sent out in ascending order, one word per
// cycle from the bottom cell of the chain while out_stall is low, with the final word
// marked; the input stays stalled until the whole set has been sent out.
module insertion_sorter_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [31:0]       in_value,
  input  logic                     in_is_last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [31:0]       out_sorted_value,
  output logic                     out_last_of_run
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  isort_pkg::state_t state_r;
  isort_pkg::state_t state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;

  logic in_acc;
  logic out_acc;

  isort_pkg::value_t   cell_value [DEPTH];
  logic                cell_gt    [DEPTH];
  isort_pkg::cell_ctl_t cell_ctl  [DEPTH];

  assign in_stall         = (state_r == isort_pkg::ST_DRAIN);
  assign out_valid        = (state_r == isort_pkg::ST_DRAIN);
  assign out_sorted_value = cell_value[0];
  assign out_last_of_run  = (count_r == CNT_W'(1));

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    unique case (state_r)
      isort_pkg::ST_LOAD: begin
        if (in_acc) begin
          count_nxt = count_r + CNT_W'(1);
          if (in_is_last || (count_r == CNT_W'(DEPTH - 1))) begin
            state_nxt = isort_pkg::ST_DRAIN;
          end
        end
      end
      isort_pkg::ST_DRAIN: begin
        if (out_acc) begin
          count_nxt = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            state_nxt = isort_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = isort_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= isort_pkg::ST_LOAD;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_ctl[i].load     = in_acc;
    assign cell_ctl[i].shift    = out_acc;
    assign cell_ctl[i].occupied = (CNT_W'(i) < count_r);
    assign cell_ctl[i].tail     = (CNT_W'(i) == count_r);

    if (i == 0) begin : g_first
      isort_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl[i]),
        .ins_value  (in_value),
        .left_value (in_value),
        .left_gt    (1'b0),
        .right_value(cell_value[i+1]),
        .value      (cell_value[i]),
        .gt         (cell_gt[i])
      );
    end else if (i == DEPTH - 1) begin : g_last
      isort_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl[i]),
        .ins_value  (in_value),
        .left_value (cell_value[i-1]),
        .left_gt    (cell_gt[i-1]),
        .right_value(cell_value[i]),
        .value      (cell_value[i]),
        .gt         (cell_gt[i])
      );
    end else begin : g_mid
      isort_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl[i]),
        .ins_value  (in_value),
        .left_value (cell_value[i-1]),
        .left_gt    (cell_gt[i-1]),
        .right_value(cell_value[i+1]),
        .value      (cell_value[i]),
        .gt         (cell_gt[i])
      );
    end
  end

  a_drain_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (count_r != '0))
    else $error("drain with an empty chain");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count beyond chain depth");

  a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_is_last) |=> (state_r == isort_pkg::ST_DRAIN))
    else $error("last word did not start the drain");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_of_run) |=> (state_r == isort_pkg::ST_LOAD && count_r == '0))
    else $error("run ended without returning to load");

endmodule
